@@ hw/rtl/sgpg_pkg.sv @@
// constants, tables and shared functions for the sphere grid point generator
// no dependencies
`timescale 1ns / 1ps
package sgpg_pkg;
	localparam int MAX_INDEX_DEF     = 1023;
	localparam int ANGLE_BITS_DEF    = 20;
	localparam int CORDIC_STAGES_DEF = 18;

	localparam int IDX_W   = 10;
	localparam int RAD_W   = 32;
	localparam int THETA_W = 20;
	localparam int PHI_W   = 21;
	localparam int UNIT_W  = 18;
	localparam int POS_W   = 34;
	localparam int CNT_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_THETA_INTERVALS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHI_INTERVALS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT_MODE   = 2'd2;

	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032875;
	localparam logic signed [33:0] UNIT_MAX = 34'sd65536;

	function automatic logic [31:0] atan_turn32(input int i);
		logic [31:0] t [32];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
			32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
			32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
			32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
		return t[i];
	endfunction

	function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [49:0] v);
		if (v > 50'sd65536) return 18'sd65536;
		if (v < -50'sd65536) return -18'sd65536;
		return v[UNIT_W-1:0];
	endfunction
endpackage

@@ hw/rtl/sphere_grid_point_generator_unit.sv @@
// Equiangular sphere grid point generator. Each input word (polar index, azimuth
// index, radius) gives one output word: theta, phi, unit vector, position, in_range.
// Channels: in_valid/in_ready input words, out_valid/out_ready output words,
// cfg_valid/cfg_ready register writes (0 theta_intervals, 1 phi_intervals,
// 2 midpoint_mode), always ready, to be written only while no word is in flight.
// Stages: one input stage, a divider of ANGLE_BITS+13 register stages, a cordic of
// CORDIC_STAGES+1 stages, one product stage and the output register.
// Throughput: one word per cycle unless the receiver stalls; the whole pipe advances together.
// When the receiver stalls with a word in the output register, the pipe freezes
// and in_ready drops; nothing is lost or repeated. A free output slot keeps
// the pipe moving.
// Reset clears all valid bits and loads the register defaults 16, 32 and 0.
`timescale 1ns / 1ps
module sphere_grid_point_generator_unit import sgpg_pkg::*; #(
	parameter int MAX_INDEX     = MAX_INDEX_DEF,
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DAT_W-1:0]     cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [IDX_W-1:0]         polar_index,
	input  logic [IDX_W-1:0]         azimuth_index,
	input  logic [RAD_W-1:0]         radius,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [THETA_W-1:0]       theta,
	output logic [PHI_W-1:0]         phi,
	output logic signed [UNIT_W-1:0] unit_x,
	output logic signed [UNIT_W-1:0] unit_y,
	output logic signed [UNIT_W-1:0] unit_z,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output logic signed [POS_W-1:0]  pos_z,
	output logic                     in_range
);
	localparam int NUM_W  = ANGLE_BITS + 12;
	localparam int DIV_W  = NUM_W;
	localparam int TAG_W  = RAD_W + 1;
	localparam int CLAT   = CORDIC_STAGES;

	logic [CFG_DAT_W-1:0] nt_q, np_q;
	logic                 mid_q;
	logic                 en;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nt_q  <= 10'd16;
			np_q  <= 10'd32;
			mid_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THETA_INTERVALS: nt_q  <= cfg_data;
				REG_PHI_INTERVALS:   np_q  <= cfg_data;
				REG_MIDPOINT_MODE:   mid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: saturate counts and indices, build numerators
	function automatic logic [CNT_W-1:0] count_of(input logic [CFG_DAT_W-1:0] r);
		if (r == '0) return CNT_W'(1);
		if (32'(r) > 32'(MAX_INDEX)) return CNT_W'(MAX_INDEX);
		return CNT_W'(r);
	endfunction

	logic [CNT_W-1:0] nt_c, np_c, it_c, ip_c;
	logic             ok_c;
	assign nt_c = count_of(nt_q);
	assign np_c = count_of(np_q);
	assign ok_c = (CNT_W'(polar_index) <= nt_c) && (CNT_W'(azimuth_index) <= np_c);
	assign it_c = (CNT_W'(polar_index) > nt_c) ? nt_c : CNT_W'(polar_index);
	assign ip_c = (CNT_W'(azimuth_index) > np_c) ? np_c : CNT_W'(azimuth_index);

	logic              v_s1;
	logic [DIV_W-1:0]  tnum_s1, pnum_s1;
	logic [CNT_W-1:0]  tden_s1, pden_s1;
	logic [TAG_W-1:0]  tag_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tnum_s1 <= DIV_W'({it_c, mid_q}) << (ANGLE_BITS - 2);
			pnum_s1 <= DIV_W'({ip_c, mid_q}) << (ANGLE_BITS - 1);
			tden_s1 <= nt_c + CNT_W'(mid_q);
			pden_s1 <= np_c + CNT_W'(mid_q);
			tag_s1  <= {ok_c, radius};
		end
	end

	logic             dv, dv_p;
	logic [DIV_W-1:0] th_q, ph_q;
	logic [TAG_W-1:0] dtag;
	logic [0:0]       unused_tag;

	sgpg_divider #(.NUM_W(DIV_W), .DEN_W(CNT_W), .TAG_W(TAG_W)) u_div_t (
		.clk, .arst_n, .en, .in_valid(v_s1), .num(tnum_s1), .den(tden_s1),
		.tag_in(tag_s1), .out_valid(dv), .quot(th_q), .tag_out(dtag));
	sgpg_divider #(.NUM_W(DIV_W), .DEN_W(CNT_W), .TAG_W(1)) u_div_p (
		.clk, .arst_n, .en, .in_valid(v_s1), .num(pnum_s1), .den(pden_s1),
		.tag_in(1'b0), .out_valid(dv_p), .quot(ph_q), .tag_out(unused_tag));

	logic [31:0] ta32, pa32;
	assign ta32 = 32'(th_q << (32 - ANGLE_BITS));
	assign pa32 = 32'(ph_q << (32 - ANGLE_BITS));

	logic signed [UNIT_W-1:0] ct, st, cp, sp;
	sgpg_cordic #(.STAGES(CLAT)) u_cor_t (.clk, .en, .angle(ta32), .cos_out(ct), .sin_out(st));
	sgpg_cordic #(.STAGES(CLAT)) u_cor_p (.clk, .en, .angle(pa32), .cos_out(cp), .sin_out(sp));

	// side pipe carrying angles, radius and flag through the cordic and product stage
	logic             sv   [CLAT+3];
	logic [DIV_W-1:0] sth  [CLAT+3];
	logic [DIV_W-1:0] sph  [CLAT+3];
	logic [TAG_W-1:0] stg  [CLAT+3];
	always_comb begin
		sv[0]  = dv && dv_p;
		sth[0] = th_q;
		sph[0] = ph_q;
		stg[0] = dtag;
	end
	for (genvar k = 0; k < CLAT + 2; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else if (en) sv[k+1] <= sv[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sth[k+1] <= sth[k];
				sph[k+1] <= sph[k];
				stg[k+1] <= stg[k];
			end
		end
	end

	// product stage: unit vector
	logic signed [UNIT_W-1:0] ux_s2, uy_s2, uz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s2 <= clamp_unit(50'((36'(cp) * 36'(st) + 36'sd32768) >>> 16));
			uy_s2 <= clamp_unit(50'((36'(sp) * 36'(st) + 36'sd32768) >>> 16));
			uz_s2 <= ct;
		end
	end

	// position stage
	logic signed [50:0] rad_s;
	logic signed [50:0] px, py, pz;
	assign rad_s = 51'($unsigned(stg[CLAT+2][RAD_W-1:0]));
	assign px = (rad_s * 51'(ux_s2) + 51'sd32768) >>> 16;
	assign py = (rad_s * 51'(uy_s2) + 51'sd32768) >>> 16;
	assign pz = (rad_s * 51'(uz_s2) + 51'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= sv[CLAT+2];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			theta    <= THETA_W'(sth[CLAT+2]);
			phi      <= PHI_W'(sph[CLAT+2]);
			unit_x   <= ux_s2;
			unit_y   <= uy_s2;
			unit_z   <= uz_s2;
			pos_x    <= POS_W'(px);
			pos_y    <= POS_W'(py);
			pos_z    <= POS_W'(pz);
			in_range <= stg[CLAT+2][RAD_W];
		end
	end
endmodule

@@ hw/rtl/sgpg_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, with round to nearest
// depends on sgpg_pkg
`timescale 1ns / 1ps
module sgpg_divider import sgpg_pkg::*; #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 11,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [NUM_W-1:0] quot,
	output logic [TAG_W-1:0] tag_out
);
	localparam int R_W = DEN_W + 1;
	logic             v_s   [NUM_W+1];
	logic [NUM_W-1:0] n_s   [NUM_W+1];
	logic [NUM_W-1:0] q_s   [NUM_W+1];
	logic [R_W-1:0]   r_s   [NUM_W+1];
	logic [DEN_W-1:0] d_s   [NUM_W+1];
	logic [TAG_W-1:0] t_s   [NUM_W+1];

	// numerator gets den/2 added up front for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= num + NUM_W'(den >> 1);
			q_s[0] <= '0;
			r_s[0] <= '0;
			d_s[0] <= den;
			t_s[0] <= tag_in;
		end
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [R_W-1:0] sh;
		logic           ge;
		assign sh = {r_s[k][R_W-2:0], n_s[k][NUM_W-1-k]};
		assign ge = sh >= R_W'(d_s[k]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				d_s[k+1] <= d_s[k];
				t_s[k+1] <= t_s[k];
				r_s[k+1] <= ge ? sh - R_W'(d_s[k]) : sh;
				q_s[k+1] <= {q_s[k][NUM_W-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quot      = q_s[NUM_W];
	assign tag_out   = t_s[NUM_W];
endmodule

@@ hw/rtl/sgpg_cordic.sv @@
// pipelined rotation-mode cordic, one micro-rotation per stage, q1.16 outputs
// depends on sgpg_pkg
`timescale 1ns / 1ps
module sgpg_cordic import sgpg_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [31:0]              angle,
	output logic signed [UNIT_W-1:0] cos_out,
	output logic signed [UNIT_W-1:0] sin_out
);
	logic signed [33:0] x_s [STAGES+1];
	logic signed [33:0] y_s [STAGES+1];
	logic signed [33:0] z_s [STAGES+1];
	logic               n_s [STAGES+1];
	logic signed [33:0] z0;
	logic signed [33:0] zf;
	logic               neg;
	logic signed [33:0] xr, yr;

	assign z0 = 34'(signed'(angle));
	always_comb begin
		zf  = z0;
		neg = 1'b0;
		if (z0 > 34'sd1073741824) begin
			zf  = z0 - 34'sd2147483648;
			neg = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			zf  = z0 + 34'sd2147483648;
			neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= zf;
			n_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= n_s[i];
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - 34'(atan_turn32(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + 34'(atan_turn32(i));
				end
			end
		end
	end

	assign xr = n_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	assign yr = n_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
	assign cos_out = clamp_unit(50'((xr + 34'sd8192) >>> 14));
	assign sin_out = clamp_unit(50'((yr + 34'sd8192) >>> 14));
endmodule

@@ hw/rtl/sgpg_checker.sv @@
// port-level checker for the sphere grid point generator, bound to the top level
// depends on sgpg_pkg
`timescale 1ns / 1ps
module sgpg_checker import sgpg_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [UNIT_W-1:0] unit_x,
	input logic signed [UNIT_W-1:0] unit_z,
	input logic [THETA_W-1:0]       theta
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unit_x))
		else $error("output word dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
	a_zrange: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_z <= 18'sd65536 && unit_z >= -18'sd65536)
		else $error("unit_z out of range");
	a_theta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> theta <= 20'd524288)
		else $error("theta beyond half turn");
endmodule

bind sphere_grid_point_generator_unit sgpg_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .unit_x, .unit_z, .theta);

@@ tb/sphere_grid_point_generator_unit_tb.sv @@
// testbench for sphere_grid_point_generator_unit: random and directed grid points with a
// self-contained integer cordic predictor, scoreboard class, and random stalls on both sides
// depends on sgpg_pkg and the rtl of the block
`timescale 1ns / 1ps
module sphere_grid_point_generator_unit_tb;
	import sgpg_pkg::*;

	localparam int LATENCY = ANGLE_BITS_DEF + CORDIC_STAGES_DEF + 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [THETA_W-1:0] theta;
		logic [PHI_W-1:0] phi;
		logic signed [UNIT_W-1:0] ux, uy, uz;
		logic signed [POS_W-1:0] px, py, pz;
		logic ok;
	} point_t;

	class grid_scoreboard;
		point_t pending[$];
		int errors;
		int checked;
		int unsigned n_theta, n_phi, mid;
		longint atan_tab[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215};

		function longint fshift(longint v, int s);
			return v >>> s;
		endfunction

		function longint clampu(longint v);
			if (v > 65536) return 65536;
			if (v < -65536) return -65536;
			return v;
		endfunction

		function int unsigned count_of(int unsigned r);
			if (r == 0) return 1;
			if (r > MAX_INDEX_DEF) return MAX_INDEX_DEF;
			return r;
		endfunction

		function void sincos(longint unsigned ang, output longint c, output longint s);
			logic [31:0] a32;
			longint z, x, y, dx, dy;
			bit neg;
			a32 = 32'(ang << (32 - ANGLE_BITS_DEF));
			z = longint'($signed(a32));
			x = 652032875;
			y = 0;
			neg = 0;
			if (z > 64'sd1073741824) begin
				z -= 64'sd2147483648;
				neg = 1;
			end else if (z < -64'sd1073741824) begin
				z += 64'sd2147483648;
				neg = 1;
			end
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = fshift(y, i);
				dy = fshift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			if (neg) begin
				x = -x; y = -y;
			end
			c = clampu(fshift(x + 8192, 14));
			s = clampu(fshift(y + 8192, 14));
		endfunction

		function longint unsigned angle_of(int unsigned idx, int unsigned cnt, int sh);
			longint unsigned num, den;
			num = longint'(2 * idx + mid) << sh;
			den = cnt + mid;
			return (num + den / 2) / den;
		endfunction

		function void note_point(int unsigned it, int unsigned ip, longint r);
			int unsigned nt, np;
			longint unsigned th, ph;
			longint ct, st, cp, sp, ux, uy;
			point_t e;
			nt = count_of(n_theta);
			np = count_of(n_phi);
			e.ok = (it <= nt) && (ip <= np);
			if (it > nt) it = nt;
			if (ip > np) ip = np;
			th = angle_of(it, nt, ANGLE_BITS_DEF - 2);
			ph = angle_of(ip, np, ANGLE_BITS_DEF - 1);
			sincos(th, ct, st);
			sincos(ph, cp, sp);
			ux = clampu(fshift(cp * st + 32768, 16));
			uy = clampu(fshift(sp * st + 32768, 16));
			e.theta = th[THETA_W-1:0];
			e.phi = ph[PHI_W-1:0];
			e.ux = ux[UNIT_W-1:0];
			e.uy = uy[UNIT_W-1:0];
			e.uz = ct[UNIT_W-1:0];
			e.px = POS_W'(fshift(r * ux + 32768, 16));
			e.py = POS_W'(fshift(r * uy + 32768, 16));
			e.pz = POS_W'(fshift(r * ct + 32768, 16));
			pending.push_back(e);
		endfunction

		function void check_point(point_t got);
			point_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word theta=%0d phi=%0d", $time, got.theta, got.phi);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.theta !== e.theta) begin
				$display("%0t: theta expected %0d actual %0d", $time, e.theta, got.theta);
				errors++;
			end
			if (got.phi !== e.phi) begin
				$display("%0t: phi expected %0d actual %0d", $time, e.phi, got.phi);
				errors++;
			end
			if (got.ux !== e.ux) begin
				$display("%0t: unit_x expected %0d actual %0d", $time, e.ux, got.ux);
				errors++;
			end
			if (got.uy !== e.uy) begin
				$display("%0t: unit_y expected %0d actual %0d", $time, e.uy, got.uy);
				errors++;
			end
			if (got.uz !== e.uz) begin
				$display("%0t: unit_z expected %0d actual %0d", $time, e.uz, got.uz);
				errors++;
			end
			if (got.px !== e.px) begin
				$display("%0t: pos_x expected %0d actual %0d", $time, e.px, got.px);
				errors++;
			end
			if (got.py !== e.py) begin
				$display("%0t: pos_y expected %0d actual %0d", $time, e.py, got.py);
				errors++;
			end
			if (got.pz !== e.pz) begin
				$display("%0t: pos_z expected %0d actual %0d", $time, e.pz, got.pz);
				errors++;
			end
			if (got.ok !== e.ok) begin
				$display("%0t: in_range expected %0d actual %0d", $time, e.ok, got.ok);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [IDX_W-1:0] polar_index = '0;
	logic [IDX_W-1:0] azimuth_index = '0;
	logic [RAD_W-1:0] radius = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [THETA_W-1:0] theta;
	logic [PHI_W-1:0] phi;
	logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic in_range;

	grid_scoreboard sb;
	int cycles = 0;
	int sent = 0;
	bit rx_calm = 0;
	bit rx_hold = 0;
	bit tx_calm = 0;

	sphere_grid_point_generator_unit u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: sample at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_point('{theta, phi, unit_x, unit_y, unit_z, pos_x, pos_y, pos_z,
				in_range});
	end

	always @(negedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (rx_hold) out_ready <= 0;
		else if (rx_calm) out_ready <= 1;
		else out_ready <= ($urandom_range(99) >= 13);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THETA_INTERVALS: sb.n_theta = val;
			REG_PHI_INTERVALS: sb.n_phi = val;
			default: sb.mid = val[0];
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_point(logic [IDX_W-1:0] it, logic [IDX_W-1:0] ip, logic [RAD_W-1:0] r);
		while (!tx_calm && $urandom_range(99) < 13) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		polar_index <= it;
		azimuth_index <= ip;
		radius <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_point(it, ip, r);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic random_points(int n, int unsigned nt, int unsigned np);
		logic [RAD_W-1:0] r;
		int unsigned lim_t, lim_p;
		lim_t = (nt == 0) ? 1 : nt;
		lim_p = (np == 0) ? 1 : np;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: r = $urandom;
				1: r = $urandom_range(65536 * 4);
				2: r = 32'hFFFF_FFFF - $urandom_range(3);
				default: r = 32'h0001_0000;
			endcase
			if ($urandom_range(9) == 0)
				send_point(IDX_W'($urandom), IDX_W'($urandom), r);
			else
				send_point(IDX_W'($urandom_range(lim_t)), IDX_W'($urandom_range(lim_p)), r);
		end
	endtask

	initial begin
		sb = new();
		sb.n_theta = 16;
		sb.n_phi = 32;
		sb.mid = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// defaults, extremes of fields
		send_point(0, 0, 0);
		send_point(16, 32, 32'hFFFF_FFFF);
		send_point(8, 8, 32'h0001_0000);
		send_point(1023, 1023, 32'hFFFF_FFFF);
		send_point(17, 0, 32'h5555_5555);
		send_point(0, 33, 32'hAAAA_AAAA);
		send_point(4, 16, 32'h8000_0000);
		drain();

		// zero counts act as one, midpoint on
		write_reg(REG_THETA_INTERVALS, 0);
		write_reg(REG_PHI_INTERVALS, 0);
		write_reg(REG_MIDPOINT_MODE, 1);
		send_point(0, 0, 32'hFFFF_FFFF);
		send_point(1, 1, 32'h0001_0000);
		send_point(2, 2, 32'h1234_5678);
		drain();

		// largest counts
		write_reg(REG_THETA_INTERVALS, 1023);
		write_reg(REG_PHI_INTERVALS, 1023);
		send_point(1023, 1023, 32'hFFFF_FFFF);
		send_point(0, 0, 32'hFFFF_FFFF);
		send_point(511, 512, 32'h0001_0000);
		drain();
		write_reg(REG_MIDPOINT_MODE, 0);
		send_point(1023, 1023, 32'hFFFF_FFFF);
		send_point(512, 256, 32'hFFFF_FFFF);
		send_point(341, 767, 32'h0000_FFFF);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			int unsigned nt, np, md;
			nt = (ph == 0) ? 1 : $urandom_range(1023);
			np = (ph == 1) ? 1 : $urandom_range(1023);
			md = $urandom_range(1);
			if (ph == 2) begin
				nt = $urandom_range(8);
				np = $urandom_range(8);
			end
			write_reg(REG_THETA_INTERVALS, CFG_DAT_W'(nt));
			write_reg(REG_PHI_INTERVALS, CFG_DAT_W'(np));
			write_reg(REG_MIDPOINT_MODE, CFG_DAT_W'(md));
			if (ph == 3) begin
				// receiver holds off long while sender keeps offering
				rx_hold = 1;
				fork
					random_points(90, nt, np);
					begin
						repeat (200) @(negedge clk);
						rx_hold = 0;
					end
				join
			end else if (ph == 4) begin
				rx_calm = 1;
				tx_calm = 1;
				random_points(90, nt, np);
				rx_calm = 0;
				tx_calm = 0;
			end else begin
				random_points(90, nt, np);
			end
			drain();
		end

		$display("sent %0d grid points, checked %0d words over directed and random phases",
			sent, sb.checked);
		$display("covered count extremes, midpoint on and off, out-of-range indices and stalls");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
